// ===== design/gpr_pkg.sv =====
`timescale 1ns / 1ps

package gpr_pkg;

  // Font geometry and cursor step.
  localparam int unsigned GLYPH_COUNT = 26;
  localparam int unsigned GLYPH_ROWS  = 5;
  localparam int unsigned GLYPH_COLS  = 5;
  localparam int unsigned GLYPH_CELLS = GLYPH_ROWS * GLYPH_COLS;
  localparam int unsigned ADVANCE     = 6;

  localparam logic [7:0] CHAR_LOW_A = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LOW_Z = 8'h7a;  // 'z'

  localparam int unsigned GLYPH_IDX_W = $clog2(GLYPH_COUNT);
  localparam int unsigned COL_W       = $clog2(GLYPH_COLS);

  // One input beat: a character and where and how to draw it.
  typedef struct packed {
    logic [7:0]  char_code;
    logic [7:0]  start_x;
    logic [7:0]  row_y;
    logic [15:0] ink_color;
    logic        new_string;
  } gpr_in_t;

  // One output beat: a single pixel write.
  typedef struct packed {
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [15:0] pixel_color;
    logic        last_pixel;
  } gpr_out_t;

  // Status of the cell scanner as seen by the top level.
  typedef struct packed {
    logic busy;
    logic emit;
  } gpr_scan_stat_t;

  // Glyph rows; bit c of a row set means column c is inked.
  localparam logic [GLYPH_COLS-1:0] FONT [GLYPH_COUNT][GLYPH_ROWS] = '{
    '{5'd15, 5'd9,  5'd15, 5'd9,  5'd9 },  // a
    '{5'd7,  5'd9,  5'd15, 5'd9,  5'd7 },  // b
    '{5'd6,  5'd9,  5'd1,  5'd9,  5'd6 },  // c
    '{5'd7,  5'd9,  5'd9,  5'd9,  5'd7 },  // d
    '{5'd15, 5'd1,  5'd15, 5'd1,  5'd15},  // e
    '{5'd7,  5'd1,  5'd7,  5'd1,  5'd1 },  // f
    '{5'd6,  5'd1,  5'd13, 5'd9,  5'd6 },  // g
    '{5'd9,  5'd9,  5'd15, 5'd9,  5'd9 },  // h
    '{5'd14, 5'd4,  5'd4,  5'd4,  5'd14},  // i
    '{5'd8,  5'd8,  5'd8,  5'd10, 5'd4 },  // j
    '{5'd9,  5'd5,  5'd3,  5'd5,  5'd9 },  // k
    '{5'd1,  5'd1,  5'd1,  5'd1,  5'd15},  // l
    '{5'd17, 5'd27, 5'd21, 5'd17, 5'd17},  // m
    '{5'd9,  5'd11, 5'd13, 5'd9,  5'd9 },  // n
    '{5'd15, 5'd9,  5'd9,  5'd9,  5'd15},  // o
    '{5'd15, 5'd9,  5'd15, 5'd1,  5'd1 },  // p
    '{5'd7,  5'd5,  5'd5,  5'd5,  5'd15},  // q
    '{5'd15, 5'd9,  5'd15, 5'd5,  5'd9 },  // r
    '{5'd7,  5'd1,  5'd7,  5'd4,  5'd7 },  // s
    '{5'd7,  5'd2,  5'd2,  5'd2,  5'd2 },  // t
    '{5'd9,  5'd9,  5'd9,  5'd9,  5'd15},  // u
    '{5'd17, 5'd17, 5'd17, 5'd10, 5'd4 },  // v
    '{5'd17, 5'd17, 5'd21, 5'd27, 5'd17},  // w
    '{5'd17, 5'd10, 5'd4,  5'd10, 5'd17},  // x
    '{5'd17, 5'd10, 5'd4,  5'd4,  5'd4 },  // y
    '{5'd15, 5'd8,  5'd4,  5'd2,  5'd15}   // z
  };

  // True for the lower-case letters that have a glyph.
  function automatic logic is_letter(input logic [7:0] code);
    return (code >= CHAR_LOW_A) && (code <= CHAR_LOW_Z);
  endfunction

  // Whole glyph in raster order: bit r*GLYPH_COLS+c is row r, column c.
  // Codes without a glyph give an empty cell.
  function automatic logic [GLYPH_CELLS-1:0] glyph_cells(input logic [7:0] code);
    logic [GLYPH_CELLS-1:0] cells;
    logic [GLYPH_IDX_W-1:0] idx;
    cells = '0;
    idx   = GLYPH_IDX_W'(code - CHAR_LOW_A);
    if (is_letter(code)) begin
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        cells[r*GLYPH_COLS +: GLYPH_COLS] = FONT[idx][r];
      end
    end
    return cells;
  endfunction

endpackage

// ===== design/gpr_glyph_scan.sv =====
`timescale 1ns / 1ps

module gpr_glyph_scan (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic [7:0]             char_code_i,
  input  logic [7:0]             base_x_i,
  input  logic [7:0]             row_y_i,
  input  logic [15:0]            ink_color_i,
  input  logic                   pix_ready_i,
  output gpr_pkg::gpr_scan_stat_t stat_o,
  output gpr_pkg::gpr_out_t      pix_o
);
  import gpr_pkg::*;

  logic [GLYPH_CELLS-1:0] cells_q, cells_d;
  logic [COL_W-1:0]       col_q, col_d;
  logic [7:0]             base_x_q, base_x_d;
  logic [7:0]             y_q, y_d;
  logic [15:0]            color_q, color_d;
  logic                   busy_q, busy_d;
  logic                   more;
  logic                   step;

  // Cells still to come after the one at the head of the shift register.
  assign more = |cells_q[GLYPH_CELLS-1:1];

  // An empty cell moves on at once; an inked one waits for the output stage.
  assign step = busy_q && (!cells_q[0] || pix_ready_i);

  // Cell shift register with column and row walk.
  always_comb begin
    cells_d  = cells_q;
    col_d    = col_q;
    base_x_d = base_x_q;
    y_d      = y_q;
    color_d  = color_q;
    busy_d   = busy_q;
    if (load_i) begin
      cells_d  = glyph_cells(char_code_i);
      col_d    = '0;
      base_x_d = base_x_i;
      y_d      = row_y_i;
      color_d  = ink_color_i;
      busy_d   = |glyph_cells(char_code_i);
    end else if (step) begin
      cells_d = cells_q >> 1;
      busy_d  = more;
      if (col_q == COL_W'(GLYPH_COLS - 1)) begin
        col_d = '0;
        y_d   = y_q + 8'd1;
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cells_q <= '0;
      col_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      cells_q <= cells_d;
      col_q   <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_x_q <= base_x_d;
    y_q      <= y_d;
    color_q  <= color_d;
  end

  // Pixel offered to the output stage.
  always_comb begin
    stat_o.busy       = busy_q;
    stat_o.emit       = busy_q && cells_q[0];
    pix_o.pixel_x     = base_x_q + 8'(col_q);
    pix_o.pixel_y     = y_q;
    pix_o.pixel_color = color_q;
    pix_o.last_pixel  = !more;
  end

endmodule

// ===== design/gpr_out_reg.sv =====
`timescale 1ns / 1ps

module gpr_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pix_valid_i,
  input  gpr_pkg::gpr_out_t pix_i,
  output logic             pix_ready_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output gpr_pkg::gpr_out_t out_data_o
);
  import gpr_pkg::*;

  logic     valid_q, valid_d;
  gpr_out_t data_q, data_d;

  // Take a new pixel whenever the held one is gone or leaves this cycle.
  assign pix_ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (pix_ready_o) begin
      valid_d = pix_valid_i;
      data_d  = pix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== design/glyph_pixel_renderer.sv =====
`timescale 1ns / 1ps

// Draws lower-case letters from a fixed 5x5 font as single pixel writes. Each
// input beat is one character; the horizontal cursor loads start_x when
// new_string is set and moves on by six after every character, wrapping at
// 8 bits. A letter is scanned through a 25-bit shift register, row by row,
// one glyph cell per clock unless an inked cell waits on a full, stalled
// output register; each inked cell leaves as one output beat, the final one
// flagged by last_pixel. A letter holds the input until the scanner has
// passed its last inked cell; a space or other non-letter code is taken
// without holding the input and writes nothing. Pixels pass through one output
// register, so the scanner moves past empty cells while a finished pixel waits.
module glyph_pixel_renderer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  gpr_pkg::gpr_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output gpr_pkg::gpr_out_t out_data_o
);
  import gpr_pkg::*;

  logic           in_accept;
  logic [7:0]     cursor_q, cursor_d;
  logic [7:0]     base_x;
  logic           pix_ready;
  gpr_scan_stat_t scan_stat;
  gpr_out_t       pix;

  // One character at a time: hold the input while the scanner works.
  assign in_stall_o = scan_stat.busy;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Cursor: left edge of the current character, then step past it.
  assign base_x = in_data_i.new_string ? in_data_i.start_x : cursor_q;

  always_comb begin
    cursor_d = cursor_q;
    if (in_accept) begin
      cursor_d = base_x + 8'(ADVANCE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
    end else begin
      cursor_q <= cursor_d;
    end
  end

  gpr_glyph_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_accept),
    .char_code_i (in_data_i.char_code),
    .base_x_i    (base_x),
    .row_y_i     (in_data_i.row_y),
    .ink_color_i (in_data_i.ink_color),
    .pix_ready_i (pix_ready),
    .stat_o      (scan_stat),
    .pix_o       (pix)
  );

  gpr_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (scan_stat.emit),
    .pix_i       (pix),
    .pix_ready_o (pix_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A character that does not start a string sits one step past the last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !in_data_i.new_string |=> cursor_q == $past(cursor_q) + 8'(ADVANCE))
    else $error("cursor did not advance by one character step");

  // Every letter has inked cells, so accepting one starts a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && is_letter(in_data_i.char_code) |=> in_stall_o)
    else $error("letter accepted without starting a scan");

  // Only a running scan may offer pixels.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !scan_stat.busy |-> !scan_stat.emit)
    else $error("pixel offered while scanner idle");

endmodule
